[rtl/stq_pkg.sv]
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sleep timer queue
// Field widths, opcodes, result status codes and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int ID_W   = 8;
    localparam int PRIO_W = 6;
    localparam int TICK_W = 63;

    // item opcodes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_TICK   = 1'b1
    } t_opcode;

    // result status codes
    localparam logic RES_WOKEN = 1'b0;
    localparam logic RES_FULL  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // latch item, register insert position
        logic ins_apply;  // write new entry, shift tail down
        logic load_rej;   // load a queue-full result
        logic load_pop;   // load head result, shift queue up
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;       // last cell occupied
        logic due0;       // head entry is due
        logic due1;       // second entry is due
        logic out_free;   // output register can take a result
    } t_stat;

endpackage

[rtl/stq_ctrl.sv]
// ----------------------------------------------------------------------------
// stq_ctrl: sequencer of the sleep timer queue
// Accepts one item at a time and steps insert, reject and wake-up pops.
// ----------------------------------------------------------------------------
module stq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_opcode,
    input  stq_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output stq_pkg::t_cmd  o_cmd
);
    import stq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_REJ  = 4'b0100,
        S_POP  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (t_opcode'(i_opcode) == OP_TICK) begin
                        n_state = S_POP;
                    end else if (i_stat.full) begin
                        n_state = S_REJ;
                    end else begin
                        n_state = S_INS;
                    end
                end
            end
            S_INS: begin
                o_cmd.ins_apply = 1'b1;
                n_state         = S_IDLE;
            end
            S_REJ: begin
                if (i_stat.out_free) begin
                    o_cmd.load_rej = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_POP: begin
                if (!i_stat.due0) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.load_pop = 1'b1;
                    if (!i_stat.due1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[rtl/stq_dpath.sv]
// ----------------------------------------------------------------------------
// stq_dpath: sorted entry cells and result register
// A row of cells kept in queue order; each cell compares itself with a new
// item, the row shifts down on insert and up on a wake-up pop.
// ----------------------------------------------------------------------------
module stq_dpath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  stq_pkg::t_cmd              i_cmd,
    input  logic [stq_pkg::ID_W-1:0]   i_sleeper_id,
    input  logic [stq_pkg::PRIO_W-1:0] i_sleeper_priority,
    input  logic [stq_pkg::TICK_W-1:0] i_wake_tick,
    input  logic [stq_pkg::TICK_W-1:0] i_now_tick,
    input  logic                       i_out_stall,
    output stq_pkg::t_stat             o_stat,
    output logic                       o_out_valid,
    output logic [stq_pkg::ID_W-1:0]   o_woken_id,
    output logic                       o_status,
    output logic                       o_last
);
    import stq_pkg::*;

    // cell storage
    logic              r_valid [QUEUE_DEPTH];
    logic [TICK_W-1:0] r_wake  [QUEUE_DEPTH];
    logic [PRIO_W-1:0] r_prio  [QUEUE_DEPTH];
    logic [ID_W-1:0]   r_id    [QUEUE_DEPTH];

    // latched item and registered insert position
    logic [ID_W-1:0]        r_in_id;
    logic [PRIO_W-1:0]      r_in_prio;
    logic [TICK_W-1:0]      r_in_wake;
    logic [TICK_W-1:0]      r_now;
    logic [QUEUE_DEPTH-1:0] r_take;
    logic [QUEUE_DEPTH-1:0] n_take;

    // result register
    logic            r_out_valid;
    logic [ID_W-1:0] r_out_id;
    logic            r_out_status;
    logic            r_out_last;

    logic out_free;

    // per-cell compare: cell is free or the new item sorts ahead of it
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_take[i] = !r_valid[i] || (i_wake_tick < r_wake[i]) ||
                        ((i_wake_tick == r_wake[i]) && (i_sleeper_priority > r_prio[i]));
        end
    end

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in_id   <= i_sleeper_id;
            r_in_prio <= i_sleeper_priority;
            r_in_wake <= i_wake_tick;
            r_now     <= i_now_tick;
            r_take    <= n_take;
        end
    end

    // cell valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_cmd.ins_apply) begin
            if (r_take[0]) begin
                r_valid[0] <= 1'b1;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (r_take[i]) begin
                    r_valid[i] <= r_valid[i-1] || !r_take[i-1];
                end
            end
        end else if (i_cmd.load_pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                r_valid[i] <= r_valid[i+1];
            end
            r_valid[QUEUE_DEPTH-1] <= 1'b0;
        end
    end

    // cell payload: new item at the first taking cell, shift below it
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_apply) begin
            if (r_take[0]) begin
                r_wake[0] <= r_in_wake;
                r_prio[0] <= r_in_prio;
                r_id[0]   <= r_in_id;
            end
            for (int i = 1; i < QUEUE_DEPTH; i++) begin
                if (r_take[i]) begin
                    if (!r_take[i-1]) begin
                        r_wake[i] <= r_in_wake;
                        r_prio[i] <= r_in_prio;
                        r_id[i]   <= r_in_id;
                    end else begin
                        r_wake[i] <= r_wake[i-1];
                        r_prio[i] <= r_prio[i-1];
                        r_id[i]   <= r_id[i-1];
                    end
                end
            end
        end else if (i_cmd.load_pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                r_wake[i] <= r_wake[i+1];
                r_prio[i] <= r_prio[i+1];
                r_id[i]   <= r_id[i+1];
            end
        end
    end

    // result register: holds while stalled
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_rej || i_cmd.load_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rej) begin
            r_out_id     <= r_in_id;
            r_out_status <= RES_FULL;
            r_out_last   <= 1'b1;
        end else if (i_cmd.load_pop) begin
            r_out_id     <= r_id[0];
            r_out_status <= RES_WOKEN;
            r_out_last   <= !o_stat.due1;
        end
    end

    // status to the controller
    assign o_stat.full     = r_valid[QUEUE_DEPTH-1];
    assign o_stat.due0     = r_valid[0] && (r_wake[0] <= r_now);
    assign o_stat.due1     = r_valid[1] && (r_wake[1] <= r_now);
    assign o_stat.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_woken_id  = r_out_id;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

endmodule

[rtl/sleep_timer_queue.sv]
// Insert: accept, then the row shifts; a rejected insert loads a queue-full result.
// Tick: accept, then one pop per cycle while output is free; none due: back to idle.
// Results leave one per cycle through an output register unless the receiver stalls;
// the next item is accepted only after the current one's last result has been loaded there.
// Reset (synchronous, active low) empties the queue at once: all valid bits clear.
// ----------------------------------------------------------------------------
// sleep_timer_queue: sorted queue of sleeping threads
// Keeps entries ordered by wake tick, then higher priority, then arrival;
// a tick pops every due entry in order, one result per woken thread.
// ----------------------------------------------------------------------------
module sleep_timer_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_opcode,
    input  logic [stq_pkg::ID_W-1:0]   i_sleeper_id,
    input  logic [stq_pkg::PRIO_W-1:0] i_sleeper_priority,
    input  logic [stq_pkg::TICK_W-1:0] i_wake_tick,
    input  logic [stq_pkg::TICK_W-1:0] i_now_tick,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [stq_pkg::ID_W-1:0]   o_woken_id,
    output logic                       o_status,
    output logic                       o_last
);
    import stq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // cells and result register
    stq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_sleeper_id       (i_sleeper_id),
        .i_sleeper_priority (i_sleeper_priority),
        .i_wake_tick        (i_wake_tick),
        .i_now_tick         (i_now_tick),
        .i_out_stall        (i_out_stall),
        .o_stat             (stat),
        .o_out_valid        (o_out_valid),
        .o_woken_id         (o_woken_id),
        .o_status           (o_status),
        .o_last             (o_last)
    );

endmodule

[rtl/stq_checker.sv]
// ----------------------------------------------------------------------------
// stq_checker: port-level checks of the sleep timer queue
// Watches the handshakes and result marks over time.
// ----------------------------------------------------------------------------
module stq_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic i_opcode,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_status,
    input logic o_last
);
    import stq_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // an accepted item blocks the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted back to back");

    // a queue-full result is always the only one of its item
    a_full_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == RES_FULL) |-> o_last)
        else $error("queue-full result without last mark");

    // an accepted insert never causes a result in the next cycle
    a_ins_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_opcode == OP_INSERT) && !o_out_valid
        |=> !o_out_valid)
        else $error("result right after an insert");

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sleep_timer_queue stq_checker u_stq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_opcode    (i_opcode),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_last      (o_last)
);

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sleep_timer_queue
// Drives insert and tick items through the input channel, predicts the woken
// and rejected threads with a sorted queue of its own, and compares every
// result field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
import stq_pkg::*;

// Sorted sleeper list plus the results it still owes the output channel
class sleep_queue_scoreboard;

    typedef struct {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [TICK_W-1:0] wake;
    } sleeper_t;

    typedef struct {
        logic [ID_W-1:0] id;
        logic            status;
        logic            last;
    } wake_result_t;

    sleeper_t     sleepers[$];
    wake_result_t owed_results[$];
    int           depth;
    int           errors;

    function new(int queue_depth);
        depth  = queue_depth;
        errors = 0;
    endfunction

    // Apply one accepted item to the sleeper list and queue its results
    function void note_item(t_opcode op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                            logic [TICK_W-1:0] wake, logic [TICK_W-1:0] now);
        sleeper_t     s;
        wake_result_t r;
        int           pos;
        int           due;
        int           i;
        if (op == OP_INSERT) begin
            if (sleepers.size() >= depth) begin
                // full: insert dropped, sleeper id bounced back
                r.id     = id;
                r.status = RES_FULL;
                r.last   = 1'b1;
                owed_results.push_back(r);
            end else begin
                // goes before the first entry it sorts ahead of
                pos = 0;
                while (pos < sleepers.size() &&
                       !(wake < sleepers[pos].wake ||
                         (wake == sleepers[pos].wake && prio > sleepers[pos].prio)))
                    pos++;
                s.id   = id;
                s.prio = prio;
                s.wake = wake;
                sleepers.insert(pos, s);
            end
        end else begin
            // pop every entry that is due, head first
            due = 0;
            while (due < sleepers.size() && sleepers[due].wake <= now)
                due++;
            for (i = 0; i < due; i++) begin
                r.id     = sleepers[0].id;
                r.status = RES_WOKEN;
                r.last   = (i == due - 1);
                owed_results.push_back(r);
                void'(sleepers.pop_front());
            end
        end
    endfunction

    // Compare one accepted result with the oldest owed one
    function void check_result(logic [ID_W-1:0] id, logic status, logic last);
        wake_result_t r;
        if (owed_results.size() == 0) begin
            $error("unexpected result: woken_id %0d status %0d last %0d", id, status, last);
            errors++;
            return;
        end
        r = owed_results.pop_front();
        if (id !== r.id) begin
            $error("woken_id: expected %0d, got %0d", r.id, id);
            errors++;
        end
        if (status !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, status);
            errors++;
        end
        if (last !== r.last) begin
            $error("last: expected %0d, got %0d", r.last, last);
            errors++;
        end
    endfunction

    function int owed();
        return owed_results.size();
    endfunction

endclass

module testbench;

    localparam int                QUEUE_DEPTH  = 16;
    localparam int                HOLD_CYCLES  = 200;
    localparam int                STALL_LIMIT  = 2000;
    localparam int                RANDOM_ITEMS = 236;
    localparam logic [TICK_W-1:0] TICK_MAX     = '1;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_opcode;
    logic [ID_W-1:0]   i_sleeper_id;
    logic [PRIO_W-1:0] i_sleeper_priority;
    logic [TICK_W-1:0] i_wake_tick;
    logic [TICK_W-1:0] i_now_tick;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [ID_W-1:0]   o_woken_id;
    logic              o_status;
    logic              o_last;

    sleep_queue_scoreboard wake_board;

    logic              calm;        // no idling on either side
    logic              hold_req;    // ask the receiver for a long hold-off
    int                quiet_cycles;
    int                insert_pct;
    logic [TICK_W-1:0] epoch_base;

    sleep_timer_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_sleeper_id      (i_sleeper_id),
        .i_sleeper_priority(i_sleeper_priority),
        .i_wake_tick       (i_wake_tick),
        .i_now_tick        (i_now_tick),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_woken_id        (o_woken_id),
        .o_status          (o_status),
        .o_last            (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                wake_board.check_result(o_woken_id, o_status, o_last);
            if (i_in_valid && !o_in_stall)
                wake_board.note_item(t_opcode'(i_opcode), i_sleeper_id, i_sleeper_priority,
                                     i_wake_tick, i_now_tick);
        end
    end

    // Watchdog: too long without any item moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("sleep_timer_queue: mismatch");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else if (hold_req) begin
                hold_req    = 1'b0;
                hold_left   = HOLD_CYCLES - 1;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = !calm && ($urandom_range(99) < 31);
            end
        end
    end

    function automatic logic [TICK_W-1:0] any_tick();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[TICK_W-1:0];
    endfunction

    // Offer one item after a random gap and wait until it is taken
    task automatic send_item(input t_opcode op, input logic [ID_W-1:0] id,
                             input logic [PRIO_W-1:0] prio,
                             input logic [TICK_W-1:0] wake, input logic [TICK_W-1:0] now);
        while (!calm && $urandom_range(99) < 31) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid         = 1'b1;
        i_opcode           = op;
        i_sleeper_id       = id;
        i_sleeper_priority = prio;
        i_wake_tick        = wake;
        i_now_tick         = now;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Unused fields carry random junk
    task automatic send_insert(input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] prio,
                               input logic [TICK_W-1:0] wake);
        send_item(OP_INSERT, id, prio, wake, any_tick());
    endtask

    task automatic send_tick(input logic [TICK_W-1:0] now);
        send_item(OP_TICK, ID_W'($urandom), PRIO_W'($urandom), any_tick(), now);
    endtask

    // Mostly near-term wake ticks around a drifting time base, some wild ones
    task automatic random_item();
        int                sel;
        logic [PRIO_W-1:0] prio;
        logic [TICK_W-1:0] wake;
        sel = $urandom_range(99);
        if ($urandom_range(99) < insert_pct) begin
            if (sel < 70)
                wake = epoch_base + TICK_W'($urandom_range(0, 40));
            else if (sel < 85)
                wake = any_tick();
            else if (sel < 92)
                wake = TICK_MAX;
            else
                wake = '0;
            // narrow priorities make ties on wake tick and priority likely
            prio = ($urandom_range(1) == 0) ? PRIO_W'($urandom_range(0, 3))
                                             : PRIO_W'($urandom_range(0, 63));
            send_insert(ID_W'($urandom_range(0, 255)), prio, wake);
        end else begin
            if (sel < 80) begin
                send_tick(epoch_base + TICK_W'($urandom_range(0, 30)));
                epoch_base = epoch_base + TICK_W'($urandom_range(0, 15));
            end else if (sel < 90) begin
                send_tick(any_tick());
            end else begin
                send_tick(TICK_MAX);
            end
        end
    endtask

    initial begin : stimulus
        int k;
        wake_board         = new(QUEUE_DEPTH);
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_opcode           = OP_INSERT;
        i_sleeper_id       = '0;
        i_sleeper_priority = '0;
        i_wake_tick        = '0;
        i_now_tick         = '0;
        calm               = 1'b0;
        hold_req           = 1'b0;
        quiet_cycles       = 0;
        insert_pct         = 60;
        epoch_base         = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // tick on an empty queue
        send_tick(TICK_MAX);
        // equal wake ticks: higher priority first, then arrival order
        send_insert(8'h00, 6'd0, '0);
        send_insert(8'hAA, 6'd63, '0);
        send_insert(8'h55, 6'd0, '0);
        send_insert(8'hFF, 6'd63, TICK_MAX);
        send_tick('0);
        // nothing due on a non-empty queue
        send_tick(TICK_MAX - 1);
        // fill to the brim, bounce one insert, then wake everybody at once
        for (k = 0; k < QUEUE_DEPTH - 1; k++) begin
            if (k % 3 == 0)
                send_insert(ID_W'(k + 1), 6'd7, TICK_W'(50));
            else
                send_insert(ID_W'($urandom_range(0, 255)), PRIO_W'($urandom_range(0, 63)),
                            TICK_W'(1000 - k));
        end
        send_insert(8'h99, 6'd21, TICK_W'(3));
        send_tick(TICK_MAX);

        // receiver backs off while several wakes pile up
        hold_req = 1'b1;
        for (k = 0; k < 6; k++)
            send_insert(ID_W'($urandom_range(0, 255)), PRIO_W'($urandom_range(0, 63)),
                        TICK_W'($urandom_range(0, 9)));
        send_tick(TICK_W'(20));
        for (k = 0; k < 3; k++)
            send_insert(ID_W'($urandom_range(0, 255)), PRIO_W'($urandom_range(0, 63)),
                        any_tick());
        send_tick(TICK_MAX);

        // random traffic in bursts, alternating balanced and fill-heavy mixes
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 30 == 0) begin
                insert_pct = ((k / 30) % 2 == 0) ? 60 : 85;
                if ($urandom_range(2) == 0)
                    epoch_base = any_tick();
            end
            calm = (k >= 100 && k < 150);
            random_item();
        end
        calm       = 1'b0;
        i_in_valid = 1'b0;

        // drain the owed results, then let the pipeline settle
        while (wake_board.owed() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (wake_board.errors == 0)
            $display("sleep_timer_queue: match");
        else
            $display("sleep_timer_queue: mismatch");
        $finish;
    end

endmodule
